// File: hdl/i2c_adc_read_sequencer_assert.svh
// Assertion macros shared by the sequencer checks.
`ifndef I2C_ADC_READ_SEQUENCER_ASSERT_SVH
`define I2C_ADC_READ_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define I2CADC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define I2CADC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/i2cadc_pkg.sv
// Package: phase map, reset values and record types of the ADC read sequencer.
package i2cadc_pkg;

  // Phase map of one read transaction
  localparam logic [6:0] PH_START  = 7'd0;
  localparam logic [6:0] PH_ADDR_W = 7'd2;
  localparam logic [6:0] PH_CHAN   = 7'd20;
  localparam logic [6:0] PH_RSTART = 7'd38;
  localparam logic [6:0] PH_ADDR_R = 7'd41;
  localparam logic [6:0] PH_RECV   = 7'd59;
  localparam logic [6:0] PH_NACK   = 7'd75;
  localparam logic [6:0] PH_STOP   = 7'd77;
  localparam logic [6:0] PH_LAST   = 7'd79;

  // Offsets inside one sent-byte segment
  localparam logic [4:0] OFF_ACK_LOW = 5'd16;

  localparam logic [6:0] RESET_DEV_ADDR = 7'd72;

  typedef struct packed {
    logic [6:0] phase;
    logic [7:0] shreg;
    logic [7:0] chan;
    logic       success;
    logic       active;
    logic       line_scl;
    logic       line_sda;
  } seq_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ok;
    logic [7:0] adc_value;
  } seq_result_t;

endpackage

// File: hdl/i2cadc_in_if.sv
// Input channel: one transfer carries a begin or tick item.
interface i2cadc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] channel;
  logic       sda_in;

  modport source (output valid, mode, channel, sda_in, input ready);
  modport sink   (input valid, mode, channel, sda_in, output ready);
endinterface

// File: hdl/i2cadc_out_if.sv
// Output channel: one transfer carries the bus levels and status of one item.
interface i2cadc_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic       ok;
  logic [7:0] adc_value;

  modport source (output valid, scl, sda_drive, busy_res, done_res, ok, adc_value,
                  input ready);
  modport sink   (input valid, scl, sda_drive, busy_res, done_res, ok, adc_value,
                  output ready);
endinterface

// File: hdl/i2cadc_step.sv
// Next-state and result logic for one item of the I2C read sequence.
module i2cadc_step (
  input  i2cadc_pkg::seq_state_t  st,
  input  logic                    mode,
  input  logic [7:0]              channel,
  input  logic                    sda_in,
  input  logic [6:0]              dev_addr,
  output i2cadc_pkg::seq_state_t  st_next,
  output i2cadc_pkg::seq_result_t res
);

  logic [6:0] base;
  logic [6:0] off_full;
  logic [4:0] off;

  // Pick the start of the sent-byte segment and form the offset into it
  always_comb begin
    if (st.phase < i2cadc_pkg::PH_CHAN) begin
      base = i2cadc_pkg::PH_ADDR_W;
    end else if (st.phase < i2cadc_pkg::PH_RSTART) begin
      base = i2cadc_pkg::PH_CHAN;
    end else begin
      base = i2cadc_pkg::PH_ADDR_R;
    end
    off_full = st.phase - base;
    off      = off_full[4:0];
  end

  // Advance one phase, or start / hold on begin items
  always_comb begin
    logic       scl_v;
    logic       sda_v;
    logic       okv;
    logic [6:0] nxt_ph;

    st_next = st;
    res     = '0;
    scl_v   = 1'b1;
    sda_v   = 1'b1;
    okv     = 1'b0;
    nxt_ph  = st.phase + 7'd1;

    if (mode) begin
      if (!st.active) begin
        st_next.chan    = channel;
        st_next.success = 1'b1;
        st_next.shreg   = '0;
        st_next.phase   = i2cadc_pkg::PH_START;
        st_next.active  = 1'b1;
      end
      res.scl       = st.line_scl;
      res.sda_drive = st.line_sda;
      res.busy_res  = 1'b1;
    end else if (!st.active) begin
      st_next.line_scl = 1'b1;
      st_next.line_sda = 1'b1;
      res.scl          = 1'b1;
      res.sda_drive    = 1'b1;
    end else begin
      case (st.phase) inside
        [i2cadc_pkg::PH_START : i2cadc_pkg::PH_ADDR_W - 7'd1]: begin
          scl_v = 1'b1;
          sda_v = (st.phase == i2cadc_pkg::PH_START);
          if (st.phase != i2cadc_pkg::PH_START) begin
            st_next.shreg = {dev_addr, 1'b0};
          end
        end
        [i2cadc_pkg::PH_ADDR_W : i2cadc_pkg::PH_RSTART - 7'd1],
        [i2cadc_pkg::PH_ADDR_R : i2cadc_pkg::PH_RECV - 7'd1]: begin
          if (off < i2cadc_pkg::OFF_ACK_LOW) begin
            // data bit: low half sets SDA, high half shifts
            scl_v = off[0];
            sda_v = st.shreg[7];
            if (off[0]) begin
              st_next.shreg = {st.shreg[6:0], 1'b0};
            end
          end else if (off == i2cadc_pkg::OFF_ACK_LOW) begin
            scl_v = 1'b0;
          end else if (sda_in) begin
            // NACK: abandon and go to stop
            st_next.success = 1'b0;
            nxt_ph          = i2cadc_pkg::PH_STOP;
          end else if (st.phase == i2cadc_pkg::PH_CHAN - 7'd1) begin
            st_next.shreg = st.chan;
          end else if (st.phase == i2cadc_pkg::PH_RECV - 7'd1) begin
            st_next.shreg = '0;
          end
        end
        [i2cadc_pkg::PH_RSTART : i2cadc_pkg::PH_ADDR_R - 7'd1]: begin
          scl_v = (st.phase != i2cadc_pkg::PH_RSTART);
          sda_v = (st.phase != i2cadc_pkg::PH_ADDR_R - 7'd1);
          if (st.phase == i2cadc_pkg::PH_ADDR_R - 7'd1) begin
            st_next.shreg = {dev_addr, 1'b1};
          end
        end
        [i2cadc_pkg::PH_RECV : i2cadc_pkg::PH_NACK - 7'd1]: begin
          // receive phases start on an odd index with SCL low
          scl_v = ~st.phase[0];
          if (!st.phase[0]) begin
            st_next.shreg = {st.shreg[6:0], sda_in};
          end
        end
        [i2cadc_pkg::PH_NACK : i2cadc_pkg::PH_STOP - 7'd1]: begin
          scl_v = (st.phase != i2cadc_pkg::PH_NACK);
        end
        [i2cadc_pkg::PH_STOP : i2cadc_pkg::PH_LAST - 7'd1]: begin
          scl_v = (st.phase != i2cadc_pkg::PH_STOP);
          sda_v = 1'b0;
        end
        default: begin
          // end of stop; an unused index ends as a failure
          if (st.phase != i2cadc_pkg::PH_LAST) begin
            st_next.success = 1'b0;
          end
          okv            = st_next.success;
          res.done_res   = 1'b1;
          res.ok         = okv;
          res.adc_value  = okv ? st.shreg : 8'd0;
          st_next.active = 1'b0;
          nxt_ph         = i2cadc_pkg::PH_START;
        end
      endcase
      st_next.phase    = nxt_ph;
      st_next.line_scl = scl_v;
      st_next.line_sda = sda_v;
      res.scl          = scl_v;
      res.sda_drive    = sda_v;
      res.busy_res     = st_next.active;
    end
  end

endmodule

// File: hdl/i2c_adc_read_sequencer.sv
// Top level: I2C master sequencer for one ADC read, one bus phase per item.
//
//   channel    dir   contents
//   in_item    in    mode, channel, sda_in
//   out_item   out   scl, sda_drive, busy_res, done_res, ok, adc_value
//   cfg_*      in    device_address write (cfg_we, cfg_wdata)
//
// The phase logic sits between the sequencer state and the result register,
// so one transfer in and one out per clock while out_item does not stall.
// The result register frees when its transfer completes in the same cycle.
// rst (synchronous) clears the phase state, drops the result and loads
// device address 72; the bus lines read as released.
// A stall on out_item holds the result and holds in_item ready low.
module i2c_adc_read_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  i2cadc_in_if.sink          in_item,
  i2cadc_out_if.source       out_item
);

  i2cadc_pkg::seq_state_t  st;
  i2cadc_pkg::seq_state_t  st_next;
  i2cadc_pkg::seq_result_t res;
  i2cadc_pkg::seq_result_t res_next;
  logic [6:0]              dev_addr;
  logic                    out_valid;
  logic                    accept;

  assign in_item.ready = !out_valid || out_item.ready;
  assign accept        = in_item.valid && in_item.ready;

  i2cadc_step u_step (
    .st       (st),
    .mode     (in_item.mode),
    .channel  (in_item.channel),
    .sda_in   (in_item.sda_in),
    .dev_addr (dev_addr),
    .st_next  (st_next),
    .res      (res_next)
  );

  // Hold sequencer state, address register and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: '0, shreg: '0, chan: '0, success: 1'b0, active: 1'b0,
              line_scl: 1'b1, line_sda: 1'b1};
      dev_addr  <= i2cadc_pkg::RESET_DEV_ADDR;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        dev_addr <= cfg_wdata;
      end
      if (accept) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_item.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the result of each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign out_item.valid     = out_valid;
  assign out_item.scl       = res.scl;
  assign out_item.sda_drive = res.sda_drive;
  assign out_item.busy_res  = res.busy_res;
  assign out_item.done_res  = res.done_res;
  assign out_item.ok        = res.ok;
  assign out_item.adc_value = res.adc_value;

endmodule

// File: hdl/i2cadc_checker.sv
// Port-level checks for the ADC read sequencer, bound to the top level.
`include "i2c_adc_read_sequencer_assert.svh"

module i2cadc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl,
  input logic       sda_drive,
  input logic       busy_res,
  input logic       done_res,
  input logic       ok,
  input logic [7:0] adc_value
);

  // Result valid and bus levels, watched together under a stall
  logic [2:0] held;

  assign held = {out_valid, scl, sda_drive};

  // A finished transaction is no longer busy
  `I2CADC_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res, "done while busy")

  // Status fields stay clear outside the done transfer
  `I2CADC_ASSERT_NOW(a_status_clear, out_valid && !done_res, !ok && adc_value == '0, "stray status")

  // A failed transaction returns no data
  `I2CADC_ASSERT_NOW(a_fail_zero, out_valid && done_res && !ok, adc_value == '0, "failure data")

  // An empty result stage always takes the offered item
  `I2CADC_ASSERT_NOW(a_take_empty, in_valid && !out_valid, in_ready, "stalled while empty")

  // A stalled result holds its levels
  `I2CADC_ASSERT_NEXT(a_hold, out_valid && !out_ready, $stable(held), "result dropped under stall")

endmodule

bind i2c_adc_read_sequencer i2cadc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_item.valid),
  .in_ready  (in_item.ready),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .scl       (out_item.scl),
  .sda_drive (out_item.sda_drive),
  .busy_res  (out_item.busy_res),
  .done_res  (out_item.done_res),
  .ok        (out_item.ok),
  .adc_value (out_item.adc_value)
);

// File: test/tb_i2c_adc_read_sequencer.sv
// Testbench for the I2C ADC read sequencer: random read transactions checked against a predictor.
module tb_i2c_adc_read_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_BEGIN = 1'b1;

  // Phases that close the SCL-high half of each acknowledge slot
  localparam logic [6:0] ACK_ADDR_W = i2cadc_pkg::PH_CHAN - 7'd1;
  localparam logic [6:0] ACK_CHAN   = i2cadc_pkg::PH_RSTART - 7'd1;
  localparam logic [6:0] ACK_ADDR_R = i2cadc_pkg::PH_RECV - 7'd1;
  localparam logic [6:0] NO_NACK    = 7'h7F;

  localparam int ITEMS_PER_ADDRESS = 425;
  localparam int MAX_REPORTS       = 10;

  // Tracks the bus sequencer state and holds the bus levels still due
  class adc_read_tracker;
    logic [6:0]              dev_addr;
    logic [6:0]              phase;
    logic [7:0]              shreg;
    logic [2:0]              bit_cnt;
    logic [7:0]              chan;
    logic                    success;
    logic                    reading;
    logic                    line_scl;
    logic                    line_sda;
    i2cadc_pkg::seq_result_t pending_levels[$];
    int                      items;
    int                      results;
    int                      errors;
    int                      reads_ok;
    int                      reads_failed;
    int                      begins_ignored;

    function new();
      dev_addr       = i2cadc_pkg::RESET_DEV_ADDR;
      phase          = i2cadc_pkg::PH_START;
      shreg          = '0;
      bit_cnt        = '0;
      chan           = '0;
      success        = 1'b0;
      reading        = 1'b0;
      line_scl       = 1'b1;
      line_sda       = 1'b1;
      items          = 0;
      results        = 0;
      errors         = 0;
      reads_ok       = 0;
      reads_failed   = 0;
      begins_ignored = 0;
    endfunction

    // One phase of a sent byte; returns 1 when the target does not acknowledge
    function logic send_bit(input logic [4:0] off, input logic sda_in,
                            output logic scl, output logic sdo);
      if (off < i2cadc_pkg::OFF_ACK_LOW) begin
        scl = off[0];
        sdo = shreg[7];
        if (off[0]) begin
          shreg   = {shreg[6:0], 1'b0};
          bit_cnt = bit_cnt + 3'd1;
        end
        return 1'b0;
      end
      sdo = 1'b1;
      if (off == i2cadc_pkg::OFF_ACK_LOW) begin
        scl = 1'b0;
        return 1'b0;
      end
      scl = 1'b1;
      return sda_in;
    endfunction

    // Advance the sequencer by one item and return the levels it reports
    function i2cadc_pkg::seq_result_t next_levels(input logic mode, input logic [7:0] ch,
                                                  input logic sda_in);
      i2cadc_pkg::seq_result_t r;
      logic [6:0]              p;
      logic [6:0]              nxt;
      logic [6:0]              seg;
      logic                    nack;
      r           = '0;
      r.scl       = 1'b1;
      r.sda_drive = 1'b1;
      p           = phase;
      nxt         = p + 7'd1;
      nack        = 1'b0;

      // Begin: latch when idle, otherwise drop; the bus does not move
      if (mode == MODE_BEGIN) begin
        if (!reading) begin
          chan    = ch;
          success = 1'b1;
          bit_cnt = '0;
          shreg   = '0;
          phase   = i2cadc_pkg::PH_START;
          reading = 1'b1;
        end else begin
          begins_ignored++;
        end
        r.scl       = line_scl;
        r.sda_drive = line_sda;
        r.busy_res  = reading;
        return r;
      end

      // Tick while idle: bus released
      if (!reading) begin
        line_scl = 1'b1;
        line_sda = 1'b1;
        return r;
      end

      if (p < i2cadc_pkg::PH_ADDR_W) begin
        r.sda_drive = (p == i2cadc_pkg::PH_START);
        if (p != i2cadc_pkg::PH_START) begin
          shreg   = {dev_addr, 1'b0};
          bit_cnt = '0;
        end
      end else if (p < i2cadc_pkg::PH_RSTART) begin
        seg  = (p < i2cadc_pkg::PH_CHAN) ? p - i2cadc_pkg::PH_ADDR_W
                                         : p - i2cadc_pkg::PH_CHAN;
        nack = send_bit(seg[4:0], sda_in, r.scl, r.sda_drive);
        if (!nack && p == ACK_ADDR_W) begin
          shreg   = chan;
          bit_cnt = '0;
        end
      end else if (p < i2cadc_pkg::PH_ADDR_R) begin
        r.scl       = (p != i2cadc_pkg::PH_RSTART);
        r.sda_drive = (p != i2cadc_pkg::PH_RSTART + 7'd2);
        if (p == i2cadc_pkg::PH_RSTART + 7'd2) begin
          shreg   = {dev_addr, 1'b1};
          bit_cnt = '0;
        end
      end else if (p < i2cadc_pkg::PH_RECV) begin
        seg  = p - i2cadc_pkg::PH_ADDR_R;
        nack = send_bit(seg[4:0], sda_in, r.scl, r.sda_drive);
        if (!nack && p == ACK_ADDR_R) begin
          shreg   = '0;
          bit_cnt = '0;
        end
      end else if (p < i2cadc_pkg::PH_NACK) begin
        seg   = p - i2cadc_pkg::PH_RECV;
        r.scl = seg[0];
        if (r.scl) begin
          shreg   = {shreg[6:0], sda_in};
          bit_cnt = bit_cnt + 3'd1;
        end
      end else if (p < i2cadc_pkg::PH_STOP) begin
        r.scl = (p != i2cadc_pkg::PH_NACK);
      end else if (p < i2cadc_pkg::PH_LAST) begin
        r.scl       = (p != i2cadc_pkg::PH_STOP);
        r.sda_drive = 1'b0;
      end else begin
        if (p != i2cadc_pkg::PH_LAST) success = 1'b0;
        r.done_res  = 1'b1;
        r.ok        = success;
        r.adc_value = success ? shreg : 8'h00;
        reading     = 1'b0;
        nxt         = i2cadc_pkg::PH_START;
        if (success) reads_ok++;
        else reads_failed++;
      end

      // A missing acknowledge skips straight to the stop condition
      if (nack) begin
        success = 1'b0;
        nxt     = i2cadc_pkg::PH_STOP;
      end
      phase      = nxt;
      line_scl   = r.scl;
      line_sda   = r.sda_drive;
      r.busy_res = reading;
      return r;
    endfunction

    function void note_item(input logic mode, input logic [7:0] ch, input logic sda_in);
      items++;
      pending_levels.push_back(next_levels(mode, ch, sda_in));
    endfunction

    function void check_levels(input i2cadc_pkg::seq_result_t got);
      i2cadc_pkg::seq_result_t want;
      logic                    bad;
      results++;
      if (pending_levels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result %0d: nothing outstanding", results);
        return;
      end
      want = pending_levels.pop_front();
      bad  = (got.scl !== want.scl) || (got.sda_drive !== want.sda_drive) ||
             (got.busy_res !== want.busy_res) || (got.done_res !== want.done_res) ||
             (got.ok !== want.ok) || (got.adc_value !== want.adc_value);
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"mismatch on result %0d: expected scl=%b sda=%b busy=%b done=%b ok=%b ",
                    "adc=%h, got scl=%b sda=%b busy=%b done=%b ok=%b adc=%h"},
                   results, want.scl, want.sda_drive, want.busy_res, want.done_res,
                   want.ok, want.adc_value, got.scl, got.sda_drive, got.busy_res,
                   got.done_res, got.ok, got.adc_value);
      end
    endfunction

    function void close_out();
      if (pending_levels.size() != 0) begin
        errors++;
        $display("%0d results never arrived", pending_levels.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [6:0] cfg_wdata;
  bit src_calm;
  i2cadc_pkg::seq_result_t seen_levels;
  logic [6:0] address_plan[4];

  adc_read_tracker tracker = new();

  i2cadc_in_if  in_if();
  i2cadc_out_if out_if();

  i2c_adc_read_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_if),
    .out_item  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short waits, now and then a long one
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int src_gap();
    if (src_calm || $urandom_range(0, 99) < 55) return 0;
    return stall_len();
  endfunction

  // Record every transfer on both channels
  always @(posedge clk) begin
    if (!rst && in_if.valid && in_if.ready)
      tracker.note_item(in_if.mode, in_if.channel, in_if.sda_in);
    if (!rst && out_if.valid && out_if.ready) begin
      seen_levels.scl       = out_if.scl;
      seen_levels.sda_drive = out_if.sda_drive;
      seen_levels.busy_res  = out_if.busy_res;
      seen_levels.done_res  = out_if.done_res;
      seen_levels.ok        = out_if.ok;
      seen_levels.adc_value = out_if.adc_value;
      tracker.check_levels(seen_levels);
    end
  end

  // Back-pressure on the result channel, with calm stretches
  initial begin
    int stall_left;
    int calm_left;
    out_if.ready = 1'b0;
    stall_left   = 0;
    calm_left    = 0;
    forever begin
      @(negedge clk);
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(50, 200);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (calm_left == 0 && $urandom_range(0, 99) < 30) stall_left = stall_len();
      end
    end
  end

  // Present one item and hold it until the transfer; returns at a falling edge
  task automatic send_item(input logic mode, input logic [7:0] ch, input logic sda);
    int gap;
    gap = src_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= mode;
    in_if.channel <= ch;
    in_if.sda_in  <= sda;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Tick until the sequencer is back to idle
  task automatic finish_read();
    while (tracker.reading)
      send_item(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // One read transaction with random content, possibly refused at one acknowledge
  task automatic run_read();
    logic [7:0] ch;
    logic [7:0] rx;
    logic [6:0] p;
    logic [6:0] nack_at;
    logic       sda;
    logic       last;
    int         r;
    int         idx;
    r  = $urandom_range(0, 99);
    ch = (r < 15) ? 8'h00 : (r < 30) ? 8'hFF : 8'($urandom_range(0, 255));
    r  = $urandom_range(0, 99);
    rx = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom_range(0, 255));
    r  = $urandom_range(0, 99);
    nack_at = (r < 8) ? ACK_ADDR_W : (r < 16) ? ACK_CHAN : (r < 24) ? ACK_ADDR_R : NO_NACK;
    src_calm = ($urandom_range(0, 4) == 0);
    send_item(MODE_BEGIN, ch, 1'($urandom_range(0, 1)));
    p = i2cadc_pkg::PH_START;
    do begin
      if ($urandom_range(0, 49) == 0)
        send_item(MODE_BEGIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if (p == ACK_ADDR_W || p == ACK_CHAN || p == ACK_ADDR_R) begin
        sda = (p == nack_at);
      end else if (p >= i2cadc_pkg::PH_RECV && p < i2cadc_pkg::PH_NACK) begin
        idx = int'(p - i2cadc_pkg::PH_RECV) / 2;
        sda = rx[7 - idx];
      end else begin
        sda = 1'($urandom_range(0, 1));
      end
      send_item(MODE_TICK, 8'($urandom_range(0, 255)), sda);
      last = (p == i2cadc_pkg::PH_LAST);
      p    = (p == nack_at) ? i2cadc_pkg::PH_STOP : p + 7'd1;
    end while (!last);
  endtask

  // Let every outstanding result drain, then idle with no item offered
  task automatic drain();
    in_if.valid <= 1'b0;
    while (tracker.pending_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_address(input logic [6:0] addr);
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.dev_addr = addr;
  endtask

  initial begin
    int start_items;
    int r;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.mode     = MODE_TICK;
    in_if.channel  = '0;
    in_if.sda_in   = 1'b0;
    src_calm       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Idle ticks, a begin, a begin while busy, then a refused write address
    send_item(MODE_TICK, 8'h00, 1'b0);
    send_item(MODE_TICK, 8'hFF, 1'b1);
    send_item(MODE_BEGIN, 8'hFF, 1'b0);
    send_item(MODE_BEGIN, 8'h00, 1'b1);
    for (int p = 0; p <= int'(ACK_ADDR_W); p++)
      send_item(MODE_TICK, 8'h00, p == int'(ACK_ADDR_W));
    repeat (3) send_item(MODE_TICK, 8'h00, 1'b0);

    // Random traffic under each device address
    address_plan[0] = 7'd0;
    address_plan[1] = 7'h7F;
    address_plan[2] = 7'($urandom_range(1, 126));
    address_plan[3] = i2cadc_pkg::RESET_DEV_ADDR;
    foreach (address_plan[i]) begin
      drain();
      write_address(address_plan[i]);
      start_items = tracker.items;
      while (tracker.items - start_items < ITEMS_PER_ADDRESS) begin
        r = $urandom_range(0, 99);
        finish_read();
        if (r < 80) begin
          run_read();
        end else if (r < 90) begin
          repeat ($urandom_range(1, 8))
            send_item(1'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(1, 4))
            send_item(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end
    finish_read();

    // Wait out the last results, then idle before the summary
    drain();
    repeat (10) @(posedge clk);
    tracker.close_out();
    $display("covered %0d items: %0d reads acknowledged, %0d cut short, %0d begins dropped",
             tracker.items, tracker.reads_ok, tracker.reads_failed, tracker.begins_ignored);
    $display("device addresses 0, 127, %0d and 72; %0d mismatches",
             address_plan[2], tracker.errors);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #20_000_000;
    $display("timeout after %0d results", tracker.results);
    $display("status: fail");
    $finish;
  end

endmodule
